// ===== rtl/multi_button_debouncer_unit_assert.svh =====
// Assertion macros shared by the debouncer RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef MULTI_BUTTON_DEBOUNCER_UNIT_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MBD_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define MBD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define MBD_ASSERT_NOW(label, clk, rst, pre, post)
`define MBD_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/mbd_pkg.sv =====
// Shared constants, codes and types of the button debouncer.
// Depends on nothing; used by every module of the block.
`default_nettype none
package mbd_pkg;
   localparam int BUTTONS      = 4;
   localparam int RAW_BITS     = 4;
   localparam int ID_W         = 3;
   localparam int CNT_W        = 8;
   localparam int TOTAL_W      = 32;
   localparam int ANSWER_W     = 32;
   localparam logic [CNT_W-1:0] CONFIRM_RESET = 8'd5;

   typedef enum logic [1:0] {
      MODE_POLL  = 2'd0,
      MODE_TAKE  = 2'd1,
      MODE_HELD  = 2'd2,
      MODE_COUNT = 2'd3
   } mode_type;

   typedef struct packed {
      logic poll_en;
      logic take_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic               deb_next;
      logic               deb;
      logic               flag;
      logic [TOTAL_W-1:0] total;
   } lane_stat_type;
endpackage
`default_nettype wire

// ===== rtl/mbd_lane.sv =====
// One button lane: stability counter, debounced state, press flag and total.
// Depends on mbd_pkg and the assertion macro header.
`default_nettype none
`include "multi_button_debouncer_unit_assert.svh"
module mbd_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mbd_pkg::lane_ctrl_type        ctrl,
   input  wire logic                          pressed,
   input  wire logic [mbd_pkg::CNT_W-1:0]     confirm,
   output mbd_pkg::lane_stat_type             stat
);
   logic [mbd_pkg::CNT_W-1:0]   cnt_ff, cnt_in, cnt_upd;
   logic                        last_ff, last_in;
   logic                        deb_ff, deb_in, deb_upd;
   logic                        flag_ff, flag_in;
   logic [mbd_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                        rise;

   // Poll update, computed whether or not a poll is present.
   always_comb begin
      if (pressed == last_ff) begin
         cnt_upd = (cnt_ff < confirm) ? cnt_ff + 8'd1 : cnt_ff;
      end else begin
         cnt_upd = '0;
      end
      rise    = 1'b0;
      deb_upd = deb_ff;
      if (cnt_upd >= confirm) begin
         rise    = pressed && !deb_ff;
         deb_upd = pressed;
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      deb_in   = deb_ff;
      flag_in  = flag_ff;
      total_in = total_ff;
      if (ctrl.poll_en) begin
         cnt_in  = cnt_upd;
         last_in = pressed;
         deb_in  = deb_upd;
         if (rise) begin
            flag_in  = 1'b1;
            total_in = total_ff + 32'd1;
         end
      end else if (ctrl.take_en) begin
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         deb_ff   <= 1'b0;
         flag_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         deb_ff   <= deb_in;
         flag_ff  <= flag_in;
         total_ff <= total_in;
      end
   end

   always_comb begin
      stat.deb_next = deb_upd;
      stat.deb      = deb_ff;
      stat.flag     = flag_ff;
      stat.total    = total_ff;
   end

   `MBD_ASSERT_NEXT(a_total_only_on_poll, clock, reset, !ctrl.poll_en, $stable(total_ff))
   `MBD_ASSERT_NEXT(a_rise_sets_flag, clock, reset, ctrl.poll_en && rise, flag_ff && deb_ff)
   `MBD_ASSERT_NEXT(a_change_clears_cnt, clock, reset, ctrl.poll_en && (pressed != last_ff), cnt_ff == '0)
endmodule
`default_nettype wire

// ===== rtl/mbd_merge.sv =====
// Merge stage: builds the answer from all lanes and holds it in the output register.
// Depends on mbd_pkg.
`default_nettype none
module mbd_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire mbd_pkg::mode_type             mode,
   input  wire logic [mbd_pkg::ID_W-1:0]      button_id,
   input  wire mbd_pkg::lane_stat_type        stat [mbd_pkg::BUTTONS],
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [mbd_pkg::ANSWER_W-1:0]       rsp_tdata,
   output logic                               rsp_tuser
);
   logic                           valid_ff, valid_in;
   logic [mbd_pkg::ANSWER_W-1:0]   answer_ff, answer_in, bitmap;
   logic                           in_range_ff, in_range_in, id_ok;
   mbd_pkg::lane_stat_type         sel;

   always_comb begin
      bitmap = '0;
      sel    = '0;
      for (int i = 0; i < mbd_pkg::BUTTONS; i++) begin
         bitmap[i] = stat[i].deb_next;
         if (32'(button_id) == 32'(i)) begin
            sel = stat[i];
         end
      end
      id_ok = 32'(button_id) < 32'(mbd_pkg::BUTTONS);
   end

   always_comb begin
      answer_in   = '0;
      in_range_in = id_ok;
      unique case (mode)
         mbd_pkg::MODE_POLL: begin
            answer_in   = bitmap;
            in_range_in = 1'b1;
         end
         mbd_pkg::MODE_TAKE:  answer_in = {31'd0, sel.flag};
         mbd_pkg::MODE_HELD:  answer_in = {31'd0, sel.deb};
         mbd_pkg::MODE_COUNT: answer_in = sel.total;
         default:             answer_in = '0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         answer_ff   <= answer_in;
         in_range_ff <= in_range_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = answer_ff;
   assign rsp_tuser  = in_range_ff;
endmodule
`default_nettype wire

// ===== rtl/multi_button_debouncer_unit.sv =====
// Top level of the button debouncer: input decode, lanes and merge stage.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
//   channel  | direction | handshake          | payload
//   req_     | in        | tvalid / tready    | tuser = mode, tdata = raw levels, button id
//   rsp_     | out       | tvalid / tready    | tdata = answer, tuser = id in range
//   csr_     | in        | wr_en, no wait     | wr_data = confirm poll count
//
// One transfer per cycle is sustained while rsp_tready stays high, set by the
// single output register behind the lane array.
// A result appears in the cycle after its request transfer.
// req_tready falls only while the output register is full and rsp_tready is low.
// Synchronous reset clears all lane state and sets the confirm count to 5.
`default_nettype none
module multi_button_debouncer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [3:0] raw_levels, [6:4] button_id
   input  wire logic [1:0]                        req_tuser,  // [1:0] mode
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [mbd_pkg::ANSWER_W-1:0]           rsp_tdata,  // [31:0] answer
   output logic                                   rsp_tuser,  // [0] id_in_range
   input  wire logic                              csr_wr_en,
   input  wire logic [mbd_pkg::CNT_W-1:0]         csr_wr_data
);
   logic [mbd_pkg::CNT_W-1:0]      confirm_ff, confirm_in;
   logic                           accept;
   mbd_pkg::mode_type              mode;
   logic [mbd_pkg::RAW_BITS-1:0]   raw_levels;
   logic [mbd_pkg::ID_W-1:0]       button_id;
   mbd_pkg::lane_stat_type         stat [mbd_pkg::BUTTONS];

   // Take a new request whenever the output register is free or draining.
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign mode       = mbd_pkg::mode_type'(req_tuser);
   assign raw_levels = req_tdata[3:0];
   assign button_id  = req_tdata[6:4];

   // Hold the confirm count; software must write it only while the block is idle (not enforced).
   assign confirm_in = csr_wr_en ? csr_wr_data : confirm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff <= mbd_pkg::CONFIRM_RESET;
      end else begin
         confirm_ff <= confirm_in;
      end
   end

   // One lane per button; buttons past the pin field read as released.
   for (genvar g = 0; g < mbd_pkg::BUTTONS; g++) begin : g_lane
      mbd_pkg::lane_ctrl_type ctrl;
      logic                   pressed;

      if (g < mbd_pkg::RAW_BITS) begin : g_pin
         assign pressed = !raw_levels[g];
      end else begin : g_nopin
         assign pressed = 1'b0;
      end

      // Advance on a poll; drop the press flag on a take for this button.
      always_comb begin
         ctrl.poll_en = accept && (mode == mbd_pkg::MODE_POLL);
         ctrl.take_en = accept && (mode == mbd_pkg::MODE_TAKE)
                        && (32'(button_id) == 32'(g));
      end

      mbd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .pressed (pressed),
         .confirm (confirm_ff),
         .stat    (stat[g])
      );
   end

   // Combine lane state into the answer and register it for transfer.
   mbd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (mode),
      .button_id  (button_id),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for multi_button_debouncer_unit: a directed table, then random polls
// and queries, checked against a cycle-free predictor of the lanes or typed-in expectations.
// Depends on mbd_pkg and the multi_button_debouncer_unit RTL only.
`timescale 1ns / 1ps

module testbench;
   localparam int IDLE_PCT      = 37;    // chance of an idle cycle on either side
   localparam int HOLD_CYCLES   = 48;    // long receiver hold-off
   localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
   localparam int SETTLE_CYCLES = 3;     // margin after the last result has come back

   typedef logic [mbd_pkg::ID_W-1:0] id_type;

   typedef struct packed {
      logic [mbd_pkg::ANSWER_W-1:0] answer;
      logic                         in_range;
   } debounce_result_type;

   typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      mbd_pkg::mode_type         mode;
      logic [3:0]                raw;
      id_type                    id;
      logic [mbd_pkg::CNT_W-1:0] confirm;
      bit                        pinned;  // expectation typed in below, not predicted
      debounce_result_type       res;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [7:0]                   req_tdata;   // [3:0] raw_levels, [6:4] button_id, [7] zero
   logic [1:0]                   req_tuser;   // [1:0] mode
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [mbd_pkg::ANSWER_W-1:0] rsp_tdata;   // [31:0] answer
   logic                         rsp_tuser;   // [0] id_in_range
   logic                         csr_wr_en;
   logic [mbd_pkg::CNT_W-1:0]    csr_wr_data;

   // Predictor state: one entry per button, plus the confirm count.
   logic [mbd_pkg::CNT_W-1:0]   confirm_cnt;
   logic [mbd_pkg::CNT_W-1:0]   steady_polls [mbd_pkg::BUTTONS];
   logic                        prev_pressed [mbd_pkg::BUTTONS];
   logic                        held_state   [mbd_pkg::BUTTONS];
   logic                        press_seen   [mbd_pkg::BUTTONS];
   logic [mbd_pkg::TOTAL_W-1:0] press_tally  [mbd_pkg::BUTTONS];

   debounce_result_type pending_results [$];
   debounce_result_type want;
   debounce_result_type predicted;
   bit                  pin_now;        // expectation of the item now on the bus is typed in
   debounce_result_type pin_res;
   int                  mismatch_count;
   int                  stall_cycles;
   bit                  calm;           // when set, neither side idles
   bit                  hold_req;       // ask the receiver for one long hold-off

   multi_button_debouncer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clear every lane and restore the reset confirm count.
   task automatic clear_lanes();
      confirm_cnt = mbd_pkg::CONFIRM_RESET;
      for (int b = 0; b < mbd_pkg::BUTTONS; b++) begin
         steady_polls[b] = '0;
         prev_pressed[b] = 1'b0;
         held_state[b]   = 1'b0;
         press_seen[b]   = 1'b0;
         press_tally[b]  = '0;
      end
   endtask

   // Work out the one result of an item and advance the lane state the way the block does.
   function automatic debounce_result_type debounce_predict(input mbd_pkg::mode_type mode,
                                                            input logic [3:0] raw,
                                                            input id_type id);
      debounce_result_type                   r;
      logic                                  pressed;
      logic [$clog2(mbd_pkg::BUTTONS)-1:0]   bi;
      r.answer   = '0;
      r.in_range = 1'b1;
      bi         = id[$clog2(mbd_pkg::BUTTONS)-1:0];
      if (mode == mbd_pkg::MODE_POLL) begin
         for (int b = 0; b < mbd_pkg::BUTTONS; b++) begin
            // pins are active low; a lane without a pin bit reads as released
            pressed = (b < mbd_pkg::RAW_BITS) ? ~raw[b] : 1'b0;
            if (pressed == prev_pressed[b]) begin
               if (steady_polls[b] < confirm_cnt)
                  steady_polls[b] = steady_polls[b] + 1'b1;
            end else begin
               steady_polls[b] = '0;
               prev_pressed[b] = pressed;
            end
            if (steady_polls[b] >= confirm_cnt) begin
               if (pressed && !held_state[b]) begin
                  press_seen[b]  = 1'b1;
                  press_tally[b] = press_tally[b] + 1'b1;
               end
               held_state[b] = pressed;
            end
            r.answer[b] = held_state[b];
         end
      end else if (id >= mbd_pkg::BUTTONS) begin
         r.in_range = 1'b0;
      end else begin
         case (mode)
            mbd_pkg::MODE_TAKE: begin
               r.answer[0]    = press_seen[bi];
               press_seen[bi] = 1'b0;
            end
            mbd_pkg::MODE_HELD: begin
               r.answer[0] = held_state[bi];
            end
            default: begin
               r.answer = press_tally[bi];
            end
         endcase
      end
      return r;
   endfunction

   // Scoreboard: sample both channels at the rising edge. Retire the older result first,
   // then queue the expectation of a request taken at this same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing expected: answer %h, id_in_range %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.answer) begin
                  $display("%0t: answer mismatch: expected %h, actual %h",
                           $time, want.answer, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.in_range) begin
                  $display("%0t: id_in_range mismatch: expected %b, actual %b",
                           $time, want.in_range, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            // always run the predictor so its state keeps pace with pinned rows
            predicted = debounce_predict(mbd_pkg::mode_type'(req_tuser), req_tdata[3:0],
                                         req_tdata[6:4]);
            pending_results.push_back(pin_now ? pin_res : predicted);
         end
         // watchdog: count cycles in which neither channel completes a transfer
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** multi_button_debouncer_unit: FAILED **");
            $finish;
         end
      end
   end

   // Receiver: drop tready at random, never while calm; on request hold it low for a long
   // stretch so the output register fills and the block stalls its input.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offer one request transfer. Enter and leave at a falling edge.
   task automatic send_item(input mbd_pkg::mode_type mode, input logic [3:0] raw,
                            input id_type id, input bit pin,
                            input debounce_result_type pres);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, id, raw};
      pin_now     = pin;
      pin_res     = pres;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has come back, then let the
   // pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the confirm count; call only while the block is idle.
   task automatic write_confirm(input logic [mbd_pkg::CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      confirm_cnt = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic stim_row_type mk_row(input row_kind_type kind,
                                           input mbd_pkg::mode_type mode,
                                           input logic [3:0] raw, input id_type id,
                                           input logic [mbd_pkg::CNT_W-1:0] confirm,
                                           input bit pinned,
                                           input logic [mbd_pkg::ANSWER_W-1:0] answer,
                                           input logic in_range);
      stim_row_type r;
      r.kind         = kind;
      r.mode         = mode;
      r.raw          = raw;
      r.id           = id;
      r.confirm      = confirm;
      r.pinned       = pinned;
      r.res.answer   = answer;
      r.res.in_range = in_range;
      return r;
   endfunction

   initial begin
      stim_row_type              dir_rows [$];
      stim_row_type              row;
      logic [mbd_pkg::CNT_W-1:0] plan [7];
      logic [3:0]                held_lv;
      logic [3:0]                raw_lv;
      id_type                    qid;
      mbd_pkg::mode_type         m;
      int                        n_items;
      int                        flip_pct;
      int                        glitch_pct;
      int                        noise_pct;
      int                        query_pct;

      // Drive every input to a known value and hold reset, then release it at a falling edge.
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = mbd_pkg::MODE_POLL;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      pin_now        = 1'b0;
      pin_res        = '0;
      calm           = 1'b0;
      hold_req       = 1'b0;
      mismatch_count = 0;
      stall_cycles   = 0;
      clear_lanes();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Pinned rows: values just after reset and ids outside the bank.
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_COUNT, 4'h0, 3'd0, '0, 1'b1,
                                32'd0, 1'b1));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_HELD,  4'h0, 3'd3, '0, 1'b1,
                                32'd0, 1'b1));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_TAKE,  4'hF, 3'd7, '0, 1'b1,
                                32'd0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_COUNT, 4'h0, 3'd4, '0, 1'b1,
                                32'd0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_HELD,  4'h0, 3'd5, '0, 1'b1,
                                32'd0, 1'b0));
      // all released, then all pressed: the first pressed reading only restarts the count
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL,  4'hF, 3'd7, '0, 1'b1,
                                32'd0, 1'b1));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL,  4'h0, 3'd0, '0, 1'b1,
                                32'd0, 1'b1));
      // five more equal polls reach the reset confirm count and register a press
      repeat (5) dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL, 4'h0, 3'd2, '0,
                                           1'b0, '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_TAKE,  4'h0, 3'd0, '0, 1'b0,
                                '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_TAKE,  4'h0, 3'd0, '0, 1'b0,
                                '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_COUNT, 4'h0, 3'd3, '0, 1'b0,
                                '0, 1'b0));
      // confirm count zero: the debounced state follows every reading at once
      dir_rows.push_back(mk_row(ROW_CFG,  mbd_pkg::MODE_POLL,  4'h0, 3'd0, 8'd0, 1'b0,
                                '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL,  4'h5, 3'd1, '0, 1'b0,
                                '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL,  4'hA, 3'd6, '0, 1'b0,
                                '0, 1'b0));
      // build counters up under the largest count, then lower it below them
      dir_rows.push_back(mk_row(ROW_CFG,  mbd_pkg::MODE_POLL,  4'h0, 3'd0, 8'd255, 1'b0,
                                '0, 1'b0));
      repeat (4) dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL, 4'h0, 3'd0, '0,
                                           1'b0, '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_CFG,  mbd_pkg::MODE_POLL,  4'h0, 3'd0, 8'd2, 1'b0,
                                '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_POLL,  4'h0, 3'd0, '0, 1'b0,
                                '0, 1'b0));
      dir_rows.push_back(mk_row(ROW_ITEM, mbd_pkg::MODE_COUNT, 4'h0, 3'd1, '0, 1'b0,
                                '0, 1'b0));

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CFG) begin
            drain();
            write_confirm(row.confirm);
         end else begin
            send_item(row.mode, row.raw, row.id, row.pinned, row.res);
         end
      end

      // Random phases, one confirm count each. Most polls follow buttons that are held
      // for a while with occasional bounces; the rest is noise.
      plan = '{8'd0, 8'd1, 8'd3, 8'd2, 8'($urandom_range(1, 6)), 8'd255, 8'd4};
      held_lv = 4'hF;
      foreach (plan[p]) begin
         drain();
         write_confirm(plan[p]);
         calm = (p == 3);
         if (p == 2)
            hold_req = 1'b1;
         if (plan[p] == 8'd255) begin
            // hold the pins steady long enough for the largest count to be reached
            n_items    = 300;
            flip_pct   = 0;
            glitch_pct = 0;
            noise_pct  = 0;
            query_pct  = 10;
            held_lv    = 4'($urandom);
         end else begin
            n_items    = 75;
            flip_pct   = 12;
            glitch_pct = 6;
            noise_pct  = 10;
            query_pct  = 40;
         end
         repeat (n_items) begin
            if ($urandom_range(99) < query_pct) begin
               m      = mbd_pkg::mode_type'($urandom_range(1, 3));
               if ($urandom_range(99) < 80)
                  qid = id_type'($urandom_range(0, mbd_pkg::BUTTONS - 1));
               else
                  qid = id_type'($urandom_range(mbd_pkg::BUTTONS, 7));
               raw_lv = 4'($urandom);
            end else begin
               m = mbd_pkg::MODE_POLL;
               for (int b = 0; b < 4; b++)
                  if ($urandom_range(99) < flip_pct)
                     held_lv[b] = ~held_lv[b];
               raw_lv = held_lv;
               for (int b = 0; b < 4; b++)
                  if ($urandom_range(99) < glitch_pct)
                     raw_lv[b] = ~raw_lv[b];
               if ($urandom_range(99) < noise_pct)
                  raw_lv = 4'($urandom);
               qid = id_type'($urandom);
            end
            send_item(m, raw_lv, qid, 1'b0, '0);
         end
      end

      calm = 1'b0;
      drain();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("** multi_button_debouncer_unit: PASSED **");
      else
         $display("** multi_button_debouncer_unit: FAILED **");
      $finish;
   end
endmodule
